// ----- hdl/vca_pkg.sv -----
// Package for the voice channel allocator.
// Holds the command opcodes, sequencer states and mixer constants; no dependencies.
package vca_pkg;

  typedef enum logic [2:0] {
    OP_PLAY     = 3'd0,
    OP_STOP     = 3'd1,
    OP_PAUSE    = 3'd2,
    OP_RESUME   = 3'd3,
    OP_QUERY    = 3'd4,
    OP_STOP_ALL = 3'd5,
    OP_FINISHED = 3'd6,
    OP_NOP      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT
  } state_t;

  localparam logic [1:0] PS_STOPPED = 2'd0;
  localparam logic [1:0] PS_PLAYING = 2'd1;
  localparam logic [1:0] PS_PAUSED  = 2'd2;

  localparam logic [7:0] MAX_GAIN = 8'd128;

endpackage

// ----- hdl/voice_channel_allocator_unit.sv -----
// Voice channel allocator: channel table in a one-port synchronous memory,
// scanned one entry per cycle, then a single read-modify-write action cycle.
// Depends on vca_pkg.
// Play, stop, pause, resume and query first scan the table, one memory read per channel,
// then run the action cycle; stop-all, finished and no-op go straight to the action
// cycle. The result is registered out of the action cycle. The next transaction may be
// accepted once the block is back in idle and busy is low.
// Reset clears the per-channel valid bits at once, so every channel reads free, and
// zeroes the handle counter. The receiver cannot stall; each result is strobed once.
module voice_channel_allocator_unit #(
  parameter int NUM_CHANNELS = 8,
  parameter int HANDLE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_target_handle,
  input  logic [2:0]  in_done_channel,
  input  logic        in_want_loop,
  input  logic [9:0]  in_sound_id,
  input  logic [7:0]  in_gain,
  output logic        out_valid,
  output logic [31:0] out_new_handle,
  output logic [2:0]  out_voice_channel,
  output logic        out_start_voice,
  output logic        out_halt_voice,
  output logic        out_halt_every,
  output logic        out_pause_voice,
  output logic        out_resume_voice,
  output logic [1:0]  out_play_state,
  output logic        out_handle_found,
  output logic        out_loop,
  output logic [9:0]  out_sound,
  output logic [7:0]  out_gain
);

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam int DW    = (CNT_W > 3) ? CNT_W : 3;
  localparam int CMP_W = (HANDLE_BITS > 32) ? HANDLE_BITS : 32;
  localparam int ENT_W = HANDLE_BITS + 2;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  // channel table: {handle, looping, paused}
  logic [ENT_W-1:0] mem [NUM_CHANNELS];

  vca_pkg::state_t state_r, state_nxt;
  logic [NUM_CHANNELS-1:0] valid_r, valid_nxt;
  logic [HANDLE_BITS-1:0]  cnt_r, cnt_nxt, cnt_inc, cnt_new;
  logic [CMP_W-1:0]        cnt_ext;

  // latched transaction
  vca_pkg::op_t op_r;
  logic [31:0]  target_r;
  logic [2:0]   done_r;
  logic         loop_r;
  logic [9:0]   sound_r;
  logic [7:0]   gain_r;

  // scan
  logic [CNT_W-1:0] iss_cnt_r;
  logic             rd_en, pend_r, rd_vld_r;
  logic [CH_W-1:0]  rd_addr, rd_idx_r;
  logic [ENT_W-1:0] rd_data_r;
  logic [HANDLE_BITS-1:0] rd_h;
  logic             rd_lp, rd_pa, rd_match;

  logic free_found_r, nl_found_r, all_found_r, m_found_r;
  logic [CH_W-1:0] free_idx_r, nl_idx_r, all_idx_r, m_idx_r;
  logic [HANDLE_BITS-1:0] nl_min_r, all_min_r, m_handle_r;
  logic m_loop_r, m_paused_r;

  // action
  logic             accept;
  logic             wr_en;
  logic [CH_W-1:0]  wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [CH_W-1:0]  play_ch, act_idx;
  logic [DW-1:0]    act_idx_w, done_w;
  logic [CH_W-1:0]  done_idx;
  logic             done_ok;
  logic [7:0]       gain_sat;

  logic        valid_out_nxt;
  logic [31:0] o_handle_nxt;
  logic [2:0]  o_ch_nxt;
  logic        o_start_nxt, o_halt_nxt, o_every_nxt, o_pause_nxt, o_resume_nxt;
  logic [1:0]  o_state_nxt;
  logic        o_found_nxt, o_loop_nxt;
  logic [9:0]  o_sound_nxt;
  logic [7:0]  o_gain_nxt;

  assign busy   = (state_r != vca_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign rd_en   = (state_r == vca_pkg::ST_SCAN) && (iss_cnt_r < CNT_W'(NUM_CHANNELS));
  assign rd_addr = iss_cnt_r[CH_W-1:0];
  assign rd_h    = rd_data_r[ENT_W-1:2];
  assign rd_lp   = rd_data_r[1];
  assign rd_pa   = rd_data_r[0];
  assign rd_match = rd_vld_r && (target_r != 32'd0) &&
                    (CMP_W'(rd_h) == CMP_W'(target_r));

  assign cnt_inc = cnt_r + 1'b1;
  assign cnt_new = (cnt_inc == '0) ? HANDLE_BITS'(1) : cnt_inc;
  assign cnt_ext = CMP_W'(cnt_new);

  assign play_ch   = free_found_r ? free_idx_r : (nl_found_r ? nl_idx_r : all_idx_r);
  assign act_idx   = (op_r == vca_pkg::OP_PLAY) ? play_ch : m_idx_r;
  assign act_idx_w = DW'(act_idx);
  assign done_w    = DW'(done_r);
  assign done_ok   = done_w < DW'(NUM_CHANNELS);
  assign done_idx  = done_w[CH_W-1:0];
  assign gain_sat  = (gain_r > vca_pkg::MAX_GAIN) ? vca_pkg::MAX_GAIN : gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vca_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    wr_en         = 1'b0;
    wr_addr       = act_idx;
    wr_data       = {m_handle_r, m_loop_r, m_paused_r};
    valid_out_nxt = 1'b0;
    o_handle_nxt  = 32'd0;
    o_ch_nxt      = 3'd0;
    o_start_nxt   = 1'b0;
    o_halt_nxt    = 1'b0;
    o_every_nxt   = 1'b0;
    o_pause_nxt   = 1'b0;
    o_resume_nxt  = 1'b0;
    o_state_nxt   = vca_pkg::PS_STOPPED;
    o_found_nxt   = 1'b0;
    o_loop_nxt    = 1'b0;
    o_sound_nxt   = 10'd0;
    o_gain_nxt    = 8'd0;
    case (state_r)
      vca_pkg::ST_IDLE: begin
        if (start) begin
          if ((in_opcode == vca_pkg::OP_PLAY) || (in_opcode == vca_pkg::OP_STOP) ||
              (in_opcode == vca_pkg::OP_PAUSE) || (in_opcode == vca_pkg::OP_RESUME) ||
              (in_opcode == vca_pkg::OP_QUERY)) begin
            state_nxt = vca_pkg::ST_SCAN;
          end else begin
            state_nxt = vca_pkg::ST_ACT;
          end
        end
      end
      vca_pkg::ST_SCAN: begin
        if (pend_r && (rd_idx_r == LAST_CH)) begin
          state_nxt = vca_pkg::ST_ACT;
        end
      end
      vca_pkg::ST_ACT: begin
        state_nxt     = vca_pkg::ST_IDLE;
        valid_out_nxt = 1'b1;
        case (op_r)
          vca_pkg::OP_PLAY: begin
            cnt_nxt            = cnt_new;
            wr_en              = 1'b1;
            wr_data            = {cnt_new, loop_r, 1'b0};
            valid_nxt[play_ch] = 1'b1;
            o_handle_nxt       = cnt_ext[31:0];
            o_ch_nxt           = act_idx_w[2:0];
            o_start_nxt        = 1'b1;
            o_halt_nxt         = !free_found_r;
            o_loop_nxt         = loop_r;
            o_sound_nxt        = sound_r;
            o_gain_nxt         = gain_sat;
          end
          vca_pkg::OP_STOP: begin
            if (m_found_r) begin
              o_found_nxt        = 1'b1;
              o_ch_nxt           = act_idx_w[2:0];
              o_halt_nxt         = 1'b1;
              valid_nxt[m_idx_r] = 1'b0;
            end
          end
          vca_pkg::OP_PAUSE: begin
            if (m_found_r) begin
              o_found_nxt = 1'b1;
              o_ch_nxt    = act_idx_w[2:0];
              if (!m_paused_r) begin
                o_pause_nxt = 1'b1;
                wr_en       = 1'b1;
                wr_data     = {m_handle_r, m_loop_r, 1'b1};
              end
            end
          end
          vca_pkg::OP_RESUME: begin
            if (m_found_r) begin
              o_found_nxt = 1'b1;
              o_ch_nxt    = act_idx_w[2:0];
              if (m_paused_r) begin
                o_resume_nxt = 1'b1;
                wr_en        = 1'b1;
                wr_data      = {m_handle_r, m_loop_r, 1'b0};
              end
            end
          end
          vca_pkg::OP_QUERY: begin
            if (m_found_r) begin
              o_found_nxt = 1'b1;
              o_ch_nxt    = act_idx_w[2:0];
              o_state_nxt = m_paused_r ? vca_pkg::PS_PAUSED : vca_pkg::PS_PLAYING;
            end
          end
          vca_pkg::OP_STOP_ALL: begin
            o_every_nxt = 1'b1;
            valid_nxt   = '0;
          end
          vca_pkg::OP_FINISHED: begin
            o_ch_nxt = done_r;
            if (done_ok && valid_r[done_idx]) begin
              o_found_nxt         = 1'b1;
              valid_nxt[done_idx] = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = vca_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      cnt_r        <= '0;
      out_valid    <= 1'b0;
      iss_cnt_r    <= '0;
      pend_r       <= 1'b0;
      free_found_r <= 1'b0;
      nl_found_r   <= 1'b0;
      all_found_r  <= 1'b0;
      m_found_r    <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      cnt_r     <= cnt_nxt;
      out_valid <= valid_out_nxt;
      pend_r    <= rd_en;
      if (accept) begin
        iss_cnt_r    <= '0;
        free_found_r <= 1'b0;
        nl_found_r   <= 1'b0;
        all_found_r  <= 1'b0;
        m_found_r    <= 1'b0;
      end else begin
        if (rd_en) begin
          iss_cnt_r <= iss_cnt_r + 1'b1;
        end
        if (pend_r) begin
          if (!rd_vld_r) begin
            if (!free_found_r) begin
              free_found_r <= 1'b1;
            end
          end else begin
            if (!rd_lp && (!nl_found_r || (rd_h < nl_min_r))) begin
              nl_found_r <= 1'b1;
            end
            all_found_r <= 1'b1;
            if (rd_match) begin
              m_found_r <= 1'b1;
            end
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= vca_pkg::op_t'(in_opcode);
      target_r <= in_target_handle;
      done_r   <= in_done_channel;
      loop_r   <= in_want_loop;
      sound_r  <= in_sound_id;
      gain_r   <= in_gain;
    end
    if (rd_en) begin
      rd_idx_r <= rd_addr;
    end
    if (pend_r && !accept) begin
      if (!rd_vld_r) begin
        if (!free_found_r) begin
          free_idx_r <= rd_idx_r;
        end
      end else begin
        if (!rd_lp && (!nl_found_r || (rd_h < nl_min_r))) begin
          nl_min_r <= rd_h;
          nl_idx_r <= rd_idx_r;
        end
        if (!all_found_r || (rd_h < all_min_r)) begin
          all_min_r <= rd_h;
          all_idx_r <= rd_idx_r;
        end
        if (rd_match && !m_found_r) begin
          m_idx_r    <= rd_idx_r;
          m_handle_r <= rd_h;
          m_loop_r   <= rd_lp;
          m_paused_r <= rd_pa;
        end
      end
    end
    if (state_r == vca_pkg::ST_ACT) begin
      out_new_handle    <= o_handle_nxt;
      out_voice_channel <= o_ch_nxt;
      out_start_voice   <= o_start_nxt;
      out_halt_voice    <= o_halt_nxt;
      out_halt_every    <= o_every_nxt;
      out_pause_voice   <= o_pause_nxt;
      out_resume_voice  <= o_resume_nxt;
      out_play_state    <= o_state_nxt;
      out_handle_found  <= o_found_nxt;
      out_loop          <= o_loop_nxt;
      out_sound         <= o_sound_nxt;
      out_gain          <= o_gain_nxt;
    end
  end

  // channel table memory; scan reads never overlap the action-cycle write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= valid_r[rd_addr];
    end
  end

endmodule
